>>> design/date_interval_inclusive_days_defines.svh
// Assertion macros for the date interval day counter
`ifndef DATE_INTERVAL_INCLUSIVE_DAYS_DEFINES_SVH
`define DATE_INTERVAL_INCLUSIVE_DAYS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DDAY_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dday: assertion failed");
`define DDAY_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dday: assertion failed");
`else
`define DDAY_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DDAY_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/dday_pkg.sv
// Types, constants and calendar tables for the date interval day counter
`default_nettype none
package dday_pkg;

  localparam int DATE_W = 27;
  localparam int DAYS_W = 22;
  localparam int DN_W   = 23;

  localparam logic [25:0] RECIP_Q100 = 26'd42949673;
  localparam logic [19:0] RECIP_Y    = 20'd671089;
  localparam logic [12:0] RECIP_C    = 13'd5243;

  localparam logic [DAYS_W-1:0] COUNT_MAX = {DAYS_W{1'b1}};

  typedef struct packed {
    logic            ok;
    logic [DN_W-1:0] dn;
  } dday_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/dday_daynum.sv
// Five-stage pipeline from a packed YYYYMMDD date to its day number and validity
`default_nettype none
module dday_daynum (
  input  logic                           clk,
  input  logic [dday_pkg::DATE_W-1:0]    date,
  output dday_pkg::dday_res_t            res
);
  import dday_pkg::*;

  logic [DATE_W-1:0] s1_v;
  logic [20:0]       s1_q100;
  logic [50:0]       p1;

  logic [6:0]        s2_d;
  logic [20:0]       s2_q100;
  logic [13:0]       s2_y;
  logic [26:0]       rem2;
  logic [38:0]       p2;

  logic [6:0]        s3_m;
  logic [6:0]        s3_d;
  logic [13:0]       s3_y;
  logic [7:0]        s3_c;
  logic [20:0]       rem3;
  logic [24:0]       p3;

  logic [13:0]       s4_y;
  logic [12:0]       s4_leaps;
  logic [8:0]        s4_md;
  logic              s4_ok;
  logic [13:0]       yr100;
  logic              yr_nz;
  logic              c_nz;
  logic              leap;
  logic [14:0]       y3p;
  logic [12:0]       leaps;
  logic [4:0]        lim;
  logic              ok4;
  logic [8:0]        md;

  assign p1 = 51'(date[DATE_W-1:2]) * 51'(RECIP_Q100);

  always_ff @(posedge clk) begin
    s1_v    <= date;
    s1_q100 <= p1[50:30];
  end

  assign rem2 = s1_v - (27'(s1_q100) * 27'd100);
  assign p2   = 39'(s1_q100[20:2]) * 39'(RECIP_Y);

  always_ff @(posedge clk) begin
    s2_d    <= rem2[6:0];
    s2_q100 <= s1_q100;
    s2_y    <= p2[37:24];
  end

  assign rem3 = s2_q100 - (21'(s2_y) * 21'd100);
  assign p3   = 25'(s2_y[13:2]) * 25'(RECIP_C);

  always_ff @(posedge clk) begin
    s3_m <= rem3[6:0];
    s3_d <= s2_d;
    s3_y <= s2_y;
    s3_c <= p3[24:17];
  end

  always_comb begin
    yr100 = s3_y - (14'(s3_c) * 14'd100);
    yr_nz = (yr100 != 14'd0);
    c_nz  = (s3_c[1:0] != 2'd0);
    leap  = ((s3_y[1:0] == 2'd0) && yr_nz) || (!yr_nz && !c_nz);
    y3p   = {1'b0, s3_y} + 15'd3;
    leaps = y3p[14:2] - ({5'd0, s3_c} + {12'd0, yr_nz})
          + ({7'd0, s3_c[7:2]} + {12'd0, (c_nz || yr_nz)});
    lim   = month_len(s3_m[3:0]) + {4'd0, ((s3_m == 7'd2) && leap)};
    ok4   = (s3_m >= 7'd1) && (s3_m <= 7'd12) && (s3_d >= 7'd1)
          && (s3_d <= {2'd0, lim});
    md    = days_before_month(s3_m[3:0]) + {8'd0, ((s3_m > 7'd2) && leap)}
          + {2'd0, s3_d};
  end

  always_ff @(posedge clk) begin
    s4_y     <= s3_y;
    s4_leaps <= leaps;
    s4_md    <= md;
    s4_ok    <= ok4;
  end

  always_ff @(posedge clk) begin
    res.ok <= s4_ok;
    res.dn <= (DN_W'(s4_y) * DN_W'(365)) + DN_W'(s4_leaps) + DN_W'(s4_md);
  end

endmodule
`default_nettype wire

>>> design/date_interval_inclusive_days.sv
// A request is accepted when start is high and busy is low; each one ends in a done strobe.
// Throughput: one request per cycle while busy is low; results arrive in request order.
// Day numbers take five stages, the absolute difference one, the count and clamp one.
// Reset clears the valid pipeline and done and sets busy; busy falls once reset is released.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "date_interval_inclusive_days_defines.svh"
module date_interval_inclusive_days (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dday_pkg::DATE_W-1:0]   first_date,
  input  logic [dday_pkg::DATE_W-1:0]   second_date,
  output logic                          done,
  output logic [dday_pkg::DAYS_W-1:0]   inclusive_days,
  output logic                          date_invalid
);
  import dday_pkg::*;

  dday_res_t         res_a;
  dday_res_t         res_b;
  logic [5:0]        vld;
  logic              ok6;
  logic [DN_W-1:0]   diff6;
  logic [DN_W:0]     cnt;

  dday_daynum u_day_a (
    .clk  (clk),
    .date (first_date),
    .res  (res_a)
  );

  dday_daynum u_day_b (
    .clk  (clk),
    .date (second_date),
    .res  (res_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[4:0], (start && !busy)};
      done <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    ok6   <= res_a.ok && res_b.ok;
    diff6 <= (res_a.dn >= res_b.dn) ? (res_a.dn - res_b.dn) : (res_b.dn - res_a.dn);
  end

  assign cnt = {1'b0, diff6} + (DN_W+1)'(1);

  always_ff @(posedge clk) begin
    date_invalid <= !ok6;
    if (!ok6) begin
      inclusive_days <= '0;
    end else if (cnt > (DN_W+1)'(COUNT_MAX)) begin
      inclusive_days <= COUNT_MAX;
    end else begin
      inclusive_days <= cnt[DAYS_W-1:0];
    end
  end

  `DDAY_ASSERT_NXT(a_done_follows, clk, rst, vld[5], done)
  `DDAY_ASSERT_NXT(a_no_spurious, clk, rst, !vld[5], !done)
  `DDAY_ASSERT_IMP(a_invalid_zero, clk, rst, done && date_invalid, inclusive_days == '0)
  `DDAY_ASSERT_IMP(a_valid_nonzero, clk, rst, done && !date_invalid, inclusive_days != '0)

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the date interval inclusive day counter
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = dday_pkg::DATE_W;
  localparam int CW = dday_pkg::DAYS_W;
  localparam int MAX_YEAR = 13421;
  localparam logic [CW-1:0] DAYS_CLAMP = {CW{1'b1}};

  typedef struct {
    logic [CW-1:0] days;
    logic          invalid;
  } day_count_t;

  class interval_scoreboard;
    day_count_t expected_q[$];
    int mismatches;
    int checked;
    int invalid_seen;
    int clamped_seen;

    static function bit is_leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    static function int unsigned month_days(int unsigned m, bit leap);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    static function bit day_index(logic [DW-1:0] packed_date, output int unsigned dn);
      int unsigned v, y, m, d, leaps, prior_days;
      bit leap;
      v = packed_date;
      y = v / 10000;
      m = (v / 100) % 100;
      d = v % 100;
      leap = is_leap_year(y);
      dn = 0;
      if (m < 1 || m > 12) return 0;
      if (d < 1 || d > month_days(m, leap)) return 0;
      prior_days = 0;
      for (int unsigned k = 1; k < m; k++) prior_days += month_days(k, leap);
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      dn = 365 * y + leaps + prior_days + d;
      return 1;
    endfunction

    function void note_request(logic [DW-1:0] a, logic [DW-1:0] b);
      int unsigned dn_a, dn_b, span;
      bit ok_a, ok_b;
      day_count_t e;
      ok_a = day_index(a, dn_a);
      ok_b = day_index(b, dn_b);
      if (!ok_a || !ok_b) begin
        e.days = '0;
        e.invalid = 1'b1;
        invalid_seen++;
      end else begin
        span = ((dn_a > dn_b) ? dn_a - dn_b : dn_b - dn_a) + 1;
        if (span > DAYS_CLAMP) begin
          span = DAYS_CLAMP;
          clamped_seen++;
        end
        e.days = span[CW-1:0];
        e.invalid = 1'b0;
      end
      expected_q.push_back(e);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(logic [CW-1:0] days, logic invalid);
      day_count_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result days=%0d invalid=%0b", days, invalid));
        return;
      end
      e = expected_q.pop_front();
      if (days !== e.days)
        report($sformatf("inclusive_days expected %0d actual %0d", e.days, days));
      if (invalid !== e.invalid)
        report($sformatf("date_invalid expected %0b actual %0b", e.invalid, invalid));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [DW-1:0] first_date = '0;
  logic [DW-1:0] second_date = '0;
  logic          done;
  logic [CW-1:0] inclusive_days;
  logic          date_invalid;

  interval_scoreboard sb = new();
  int requests;

  always #10 clk = ~clk;

  date_interval_inclusive_days u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_date     (first_date),
    .second_date    (second_date),
    .done           (done),
    .inclusive_days (inclusive_days),
    .date_invalid   (date_invalid)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(inclusive_days, date_invalid);
  end

  // called and returns at a falling edge; start stays high after acceptance
  task automatic send_request(logic [DW-1:0] a, logic [DW-1:0] b, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      first_date <= DW'($urandom);
      second_date <= DW'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    first_date <= a;
    second_date <= b;
    do @(posedge clk); while (busy);
    sb.note_request(a, b);
    requests++;
    @(negedge clk);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] pack_date(int unsigned y, int unsigned m, int unsigned d);
    return DW'(y * 10000 + m * 100 + d);
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, MAX_YEAR);
      1:       return $urandom_range(0, 3) * 100 + $urandom_range(0, 4) * 400;
      default: return $urandom_range(1890, 2110);
    endcase
  endfunction

  function automatic logic [DW-1:0] valid_date(int unsigned y);
    int unsigned m;
    m = $urandom_range(1, 12);
    return pack_date(y, m, $urandom_range(1,
      interval_scoreboard::month_days(m, interval_scoreboard::is_leap_year(y))));
  endfunction

  function automatic logic [DW-1:0] broken_date();
    int unsigned y, m;
    y = pick_year();
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: return pack_date(y, 0, $urandom_range(0, 99));
      1: return pack_date(y, $urandom_range(13, 99), $urandom_range(0, 99));
      2: return pack_date(y, m, 0);
      default: return pack_date(y, m, $urandom_range(
        interval_scoreboard::month_days(m, interval_scoreboard::is_leap_year(y)) + 1, 99));
    endcase
  endfunction

  initial begin
    logic [DW-1:0] dir_a[$];
    logic [DW-1:0] dir_b[$];
    logic [DW-1:0] a, b;
    int gap;
    bit burst;

    dir_a = '{27'd20240101, 27'd20231231, 27'd20240101, 27'd20240228, 27'd19000228,
              27'd20000229, 27'd19000229, 27'd00000229, 27'd0,        27'd20241301,
              27'd20240100, 27'd20240132, 27'd20240431, 27'd20249999, 27'd00000101,
              27'd00000101, 27'd134211231, 27'h7FFFFFF, 27'h7FFFFFF, 27'd100000101,
              27'd0,        27'd20230229, 27'd40000229, 27'd21000229};
    dir_b = '{27'd20240101, 27'd20240101, 27'd20231231, 27'd20240301, 27'd19000301,
              27'd20000301, 27'd20000101, 27'd00000301, 27'd20240101, 27'd20240101,
              27'd20240101, 27'd20240101, 27'd20240101, 27'd20240101, 27'd99991231,
              27'd134211231, 27'd00000101, 27'd20240101, 27'h7FFFFFF, 27'd100001231,
              27'd0,        27'd20230301, 27'd40000301, 27'd21000301};

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_a[i]) send_request(dir_a[i], dir_b[i], (i % 3 == 0) ? $urandom_range(0, 10) : 0);
    drain_requests();

    burst = 0;
    for (int n = 0; n < 400; n++) begin
      if (n % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 100 == 99) drain_requests();
      case ($urandom_range(0, 9))
        0: begin
          a = DW'($urandom);
          b = DW'($urandom);
        end
        1: begin
          a = broken_date();
          b = valid_date(pick_year());
          if ($urandom_range(0, 1)) {a, b} = {b, a};
        end
        2, 3: begin
          a = valid_date(pick_year());
          b = valid_date(a / 10000);
        end
        default: begin
          a = valid_date(pick_year());
          b = valid_date(pick_year());
        end
      endcase
      gap = burst ? 0 : $urandom_range(0, 10);
      send_request(a, b, gap);
    end
    start <= 1'b0;

    for (int w = 0; w < 2000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d requests: %0d flagged invalid, %0d clamped at the count limit.",
             requests, sb.invalid_seen, sb.clamped_seen);
    $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
             sb.checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for the day counter.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
